/* hw/rtl/lea_pkg.sv */
// lea_pkg: shared types and constants for the luminance eye adaptation block
// used by lea_ctrl, lea_dp and luminance_eye_adaptation; no dependencies
package lea_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_TICK_FREQ  = 2'd0;
    localparam logic [1:0] REG_KEY        = 2'd1;
    localparam logic [1:0] REG_TAU_BRIGHT = 2'd2;
    localparam logic [1:0] REG_TAU_DARK   = 2'd3;

    // configuration reset values
    localparam logic [31:0] TICK_FREQ_RST  = 32'd10000000;
    localparam logic [15:0] KEY_RST        = 16'd2621;
    localparam logic [15:0] TAU_BRIGHT_RST = 16'd26214;
    localparam logic [15:0] TAU_DARK_RST   = 16'd6554;

    // fixed point constants
    localparam logic [31:0] ONE_Q31   = 32'h8000_0000;
    localparam logic [16:0] ONE_Q16   = 17'h1_0000;
    localparam logic [47:0] DELTA_SAT = 48'hFFFF_FFFF_FFFF;

    // sequencing counts; all but TERM_COUNT are one less than their pass count
    localparam logic [6:0] DELTA_STEPS   = 7'd95;
    localparam logic [6:0] SIGMA_STEPS   = 7'd16;
    localparam logic [6:0] SQUARE_PASSES = 7'd5;
    localparam logic [3:0] TERM_COUNT    = 4'd10;

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_LOAD,
        OP_DIV_STEP,
        OP_DELTA,
        OP_SIGMA,
        OP_MUL_SB,
        OP_MUL_ST,
        OP_TAU,
        OP_MUL_XLO,
        OP_MUL_XHI,
        OP_X,
        OP_MUL_TY,
        OP_MUL_RN,
        OP_TERM,
        OP_MUL_SQ,
        OP_SQ,
        OP_MUL_A,
        OP_UPDATE
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic [3:0] n;
    } t_dp_cmd;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DIV_D,
        S_DELTA,
        S_DIV_S,
        S_SIGMA,
        S_MUL_SB,
        S_MUL_ST,
        S_TAU,
        S_MUL_XLO,
        S_MUL_XHI,
        S_X,
        S_MUL_TY,
        S_MUL_RN,
        S_TERM,
        S_MUL_SQ,
        S_SQ,
        S_MUL_A,
        S_UPDATE
    } t_state;

endpackage

/* hw/rtl/luminance_eye_adaptation.sv */
// luminance_eye_adaptation: top level joining the sequencer and the datapath
// depends on lea_pkg, lea_ctrl and lea_dp
//
// Usage:
// - input channel: i_in_valid with i_measured_luminance (Q16.16) and
//   i_frame_timestamp; a transfer happens when i_in_valid is high and
//   o_in_stall is low
// - output channel: o_out_valid with o_adapted_luminance_out (Q16.16);
//   a transfer happens when o_out_valid is high and i_out_stall is low
// - configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
//   (0 tick frequency, 1 key, 2 tau bright, 3 tau dark); the user must write
//   only while idle; the block does not enforce it
// - processing of an item is set by the bit-serial shared divider (96 steps
//   for elapsed time, 17 for sigma), the 10 series terms and the shared
//   multiplier used for the squarings; one item is processed at a time
// - o_in_stall is high from an input transfer until the result is
//   registered; the next item may enter while the result still waits
// - a stalled receiver holds the result; the block finishes the next item
//   and waits at its last step until the earlier result is taken
// - reset (synchronous, active low) restores register defaults, clears the
//   adapted level and the previous timestamp, and empties both channels
module luminance_eye_adaptation import lea_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_measured_luminance,
    input  logic [63:0] i_frame_timestamp,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_adapted_luminance_out
);

    t_dp_cmd cmd;

    // sequencer
    lea_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    // arithmetic and state
    lea_dp u_dp (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_cfg_we                (i_cfg_we),
        .i_cfg_index             (i_cfg_index),
        .i_cfg_data              (i_cfg_data),
        .i_measured_luminance    (i_measured_luminance),
        .i_frame_timestamp       (i_frame_timestamp),
        .i_cmd                   (cmd),
        .o_adapted_luminance_out (o_adapted_luminance_out)
    );

endmodule

/* hw/rtl/lea_dp.sv */
// lea_dp: datapath with configuration registers, shared restoring divider,
// shared 32x32 multiplier and the adapted level; depends on lea_pkg
module lea_dp import lea_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic [31:0] i_measured_luminance,
    input  logic [63:0] i_frame_timestamp,
    input  t_dp_cmd     i_cmd,
    output logic [31:0] o_adapted_luminance_out
);

    logic [31:0] r_tick_freq;
    logic [15:0] r_key;
    logic [15:0] r_tau_b;
    logic [15:0] r_tau_d;
    logic [31:0] r_adapted;
    logic [63:0] r_prev_ts;

    logic [31:0] r_lum;
    logic [32:0] r_rem;
    logic [32:0] r_div;
    logic [95:0] r_dvd;
    logic [47:0] r_delta;
    logic [16:0] r_sigma;
    logic [15:0] r_tau;
    logic [63:0] r_prod;
    logic [63:0] r_acc;
    logic [29:0] r_y;
    logic        r_big;
    logic [31:0] r_term;
    logic [31:0] r_sum;

    logic [63:0] ticks;
    logic [31:0] freq_eff;
    logic [33:0] rem_sh;
    logic        take;
    logic [33:0] rem_nx;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic        mul_en;
    logic [33:0] tau_sum;
    logic [63:0] x_full;
    logic [31:0] rcp;
    logic [31:0] quot;
    logic [31:0] factor;
    logic        lum_ge;
    logic [31:0] diff;
    logic [32:0] denom;

    // elapsed ticks and divisor guard
    assign ticks    = i_frame_timestamp - r_prev_ts;
    assign freq_eff = (r_tick_freq == 32'd0) ? 32'd1 : r_tick_freq;
    assign denom    = {17'd0, r_key} + {1'b0, r_lum};

    // one restoring division step
    assign rem_sh = {r_rem, r_dvd[95]};
    assign take   = (rem_sh >= {1'b0, r_div});
    assign rem_nx = take ? (rem_sh - {1'b0, r_div}) : rem_sh;

    // tau blend and scaled exponent argument
    assign tau_sum = {1'b0, r_acc[32:0]} + {1'b0, r_prod[32:0]};
    assign x_full  = {r_prod[31:0], 32'd0} + r_acc;

    // series term divided by its index: reciprocal multiply and shift,
    // exact for dividends below 2^30
    always_comb begin
        rcp  = 32'd0;
        quot = 32'd0;
        case (i_cmd.n)
            4'd1: begin
                rcp  = 32'h8000_0000;
                quot = r_prod[62:31];
            end
            4'd2: begin
                rcp  = 32'h8000_0000;
                quot = r_prod[63:32];
            end
            4'd3: begin
                rcp  = 32'hAAAA_AAAB;
                quot = {1'b0, r_prod[63:33]};
            end
            4'd4: begin
                rcp  = 32'h8000_0000;
                quot = {1'b0, r_prod[63:33]};
            end
            4'd5: begin
                rcp  = 32'hCCCC_CCCD;
                quot = {2'd0, r_prod[63:34]};
            end
            4'd6: begin
                rcp  = 32'hAAAA_AAAB;
                quot = {2'd0, r_prod[63:34]};
            end
            4'd7: begin
                rcp  = 32'h9249_2493;
                quot = {2'd0, r_prod[63:34]};
            end
            4'd8: begin
                rcp  = 32'h8000_0000;
                quot = {2'd0, r_prod[63:34]};
            end
            4'd9: begin
                rcp  = 32'hE38E_38E4;
                quot = {3'd0, r_prod[63:35]};
            end
            4'd10: begin
                rcp  = 32'hCCCC_CCCD;
                quot = {3'd0, r_prod[63:35]};
            end
            default: begin
                rcp  = 32'd0;
                quot = 32'd0;
            end
        endcase
    end

    // final blend toward the measured level
    assign factor = r_big ? ONE_Q31 : (ONE_Q31 - r_sum);
    assign lum_ge = (r_lum >= r_adapted);
    assign diff   = lum_ge ? (r_lum - r_adapted) : (r_adapted - r_lum);

    // shared multiplier operand select
    always_comb begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        case (i_cmd.op)
            OP_MUL_SB: begin
                mul_a = {15'd0, r_sigma};
                mul_b = {16'd0, r_tau_b};
            end
            OP_MUL_ST: begin
                mul_a = {15'd0, ONE_Q16 - r_sigma};
                mul_b = {16'd0, r_tau_d};
            end
            OP_MUL_XLO: begin
                mul_a = r_delta[31:0];
                mul_b = {16'd0, r_tau};
            end
            OP_MUL_XHI: begin
                mul_a = {16'd0, r_delta[47:32]};
                mul_b = {16'd0, r_tau};
            end
            OP_MUL_TY: begin
                mul_a = r_term;
                mul_b = {2'd0, r_y};
            end
            OP_MUL_RN: begin
                mul_a = r_prod[62:31];
                mul_b = rcp;
            end
            OP_MUL_SQ: begin
                mul_a = r_sum;
                mul_b = r_sum;
            end
            OP_MUL_A: begin
                mul_a = diff;
                mul_b = factor;
            end
            default: begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    assign mul_p  = mul_a * mul_b;
    assign mul_en = (i_cmd.op == OP_MUL_SB) || (i_cmd.op == OP_MUL_ST)
                 || (i_cmd.op == OP_MUL_XLO) || (i_cmd.op == OP_MUL_XHI)
                 || (i_cmd.op == OP_MUL_TY) || (i_cmd.op == OP_MUL_RN)
                 || (i_cmd.op == OP_MUL_SQ) || (i_cmd.op == OP_MUL_A);

    // configuration, adapted level and timestamp history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_freq <= TICK_FREQ_RST;
            r_key       <= KEY_RST;
            r_tau_b     <= TAU_BRIGHT_RST;
            r_tau_d     <= TAU_DARK_RST;
            r_adapted   <= 32'd0;
            r_prev_ts   <= 64'd0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_TICK_FREQ:  r_tick_freq <= i_cfg_data;
                    REG_KEY:        r_key       <= i_cfg_data[15:0];
                    REG_TAU_BRIGHT: r_tau_b     <= i_cfg_data[15:0];
                    REG_TAU_DARK:   r_tau_d     <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_cmd.op == OP_LOAD) begin
                r_prev_ts <= i_frame_timestamp;
            end
            if (i_cmd.op == OP_UPDATE) begin
                if (lum_ge) begin
                    r_adapted <= r_adapted + r_prod[62:31];
                end else begin
                    r_adapted <= r_adapted - r_prod[62:31];
                end
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= mul_p;
        end
        case (i_cmd.op)
            OP_LOAD: begin
                r_lum <= i_measured_luminance;
                r_rem <= 33'd0;
                r_div <= {1'b0, freq_eff};
                r_dvd <= {ticks, 32'd0};
            end
            OP_DIV_STEP: begin
                r_rem <= rem_nx[32:0];
                r_dvd <= {r_dvd[94:0], take};
            end
            OP_DELTA: begin
                r_delta <= (r_dvd[95:48] != 48'd0) ? DELTA_SAT : r_dvd[47:0];
                r_rem   <= {18'd0, r_key[15:1]};
                r_div   <= denom;
                r_dvd   <= {r_key[0], 95'd0};
            end
            OP_SIGMA: begin
                r_sigma <= (denom == 33'd0) ? 17'd0 : r_dvd[16:0];
            end
            OP_MUL_ST: begin
                r_acc <= r_prod;
            end
            OP_TAU: begin
                r_tau <= tau_sum[31:16];
            end
            OP_MUL_XHI: begin
                r_acc <= r_prod;
            end
            OP_X: begin
                r_big  <= (x_full[63:53] != 11'd0);
                r_y    <= x_full[52:23];
                r_term <= ONE_Q31;
                r_sum  <= ONE_Q31;
            end
            OP_TERM: begin
                r_term <= quot;
                if (i_cmd.n[0]) begin
                    r_sum <= (r_sum >= quot) ? (r_sum - quot) : 32'd0;
                end else begin
                    r_sum <= r_sum + quot;
                end
            end
            OP_SQ: begin
                r_sum <= r_prod[62:31];
            end
            default: ;
        endcase
    end

    assign o_adapted_luminance_out = r_adapted;

endmodule

/* hw/rtl/lea_ctrl.sv */
// lea_ctrl: sequencer for the adaptation datapath and the channel handshakes
// depends on lea_pkg
module lea_ctrl import lea_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_dp_cmd o_cmd
);

    t_state     r_state;
    t_state     n_state;
    logic [6:0] r_cnt;
    logic [6:0] n_cnt;
    logic [3:0] r_n;
    logic [3:0] n_n;
    logic       r_out_valid;
    logic       n_out_valid;

    // state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= 7'd0;
            r_n         <= 4'd1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_n         <= n_n;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_n         = r_n;
        n_out_valid = r_out_valid & i_out_stall;
        o_cmd.op    = OP_IDLE;
        o_cmd.n     = r_n;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_cnt    = DELTA_STEPS;
                    n_state  = S_DIV_D;
                end
            end
            S_DIV_D: begin
                o_cmd.op = OP_DIV_STEP;
                if (r_cnt == 7'd0) begin
                    n_state = S_DELTA;
                end else begin
                    n_cnt = r_cnt - 7'd1;
                end
            end
            S_DELTA: begin
                o_cmd.op = OP_DELTA;
                n_cnt    = SIGMA_STEPS;
                n_state  = S_DIV_S;
            end
            S_DIV_S: begin
                o_cmd.op = OP_DIV_STEP;
                if (r_cnt == 7'd0) begin
                    n_state = S_SIGMA;
                end else begin
                    n_cnt = r_cnt - 7'd1;
                end
            end
            S_SIGMA: begin
                o_cmd.op = OP_SIGMA;
                n_state  = S_MUL_SB;
            end
            S_MUL_SB: begin
                o_cmd.op = OP_MUL_SB;
                n_state  = S_MUL_ST;
            end
            S_MUL_ST: begin
                o_cmd.op = OP_MUL_ST;
                n_state  = S_TAU;
            end
            S_TAU: begin
                o_cmd.op = OP_TAU;
                n_state  = S_MUL_XLO;
            end
            S_MUL_XLO: begin
                o_cmd.op = OP_MUL_XLO;
                n_state  = S_MUL_XHI;
            end
            S_MUL_XHI: begin
                o_cmd.op = OP_MUL_XHI;
                n_state  = S_X;
            end
            S_X: begin
                o_cmd.op = OP_X;
                n_n      = 4'd1;
                n_state  = S_MUL_TY;
            end
            S_MUL_TY: begin
                o_cmd.op = OP_MUL_TY;
                n_state  = S_MUL_RN;
            end
            S_MUL_RN: begin
                o_cmd.op = OP_MUL_RN;
                n_state  = S_TERM;
            end
            S_TERM: begin
                o_cmd.op = OP_TERM;
                if (r_n == TERM_COUNT) begin
                    n_cnt   = SQUARE_PASSES;
                    n_state = S_MUL_SQ;
                end else begin
                    n_n     = r_n + 4'd1;
                    n_state = S_MUL_TY;
                end
            end
            S_MUL_SQ: begin
                o_cmd.op = OP_MUL_SQ;
                n_state  = S_SQ;
            end
            S_SQ: begin
                o_cmd.op = OP_SQ;
                if (r_cnt == 7'd0) begin
                    n_state = S_MUL_A;
                end else begin
                    n_cnt   = r_cnt - 7'd1;
                    n_state = S_MUL_SQ;
                end
            end
            S_MUL_A: begin
                o_cmd.op = OP_MUL_A;
                n_state  = S_UPDATE;
            end
            S_UPDATE: begin
                // hold until the previous result has gone out
                if (!(r_out_valid && i_out_stall)) begin
                    o_cmd.op    = OP_UPDATE;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_DIV_D))
        else $error("accepted transfer did not start the elapsed time division");

    a_result_from_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_UPDATE))
        else $error("result raised outside the update step");

    a_term_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TERM) |-> (r_n >= 4'd1 && r_n <= TERM_COUNT))
        else $error("series term index out of range");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> (o_cmd.op != OP_UPDATE))
        else $error("pending result overwritten");
`endif

endmodule
